// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/pbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types and constants of the pulse beat detector.
// ----------------------------------------------------------------------------
`default_nettype none

package pbd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int TIME_W   = 32;
	localparam int THR_W    = 15;
	localparam int FLOOR_W  = 8;
	localparam int CEIL_W   = 16;
	localparam int BPM_W    = 16;
	localparam int AVG_W    = 8;

	localparam int PBD_RING_DEPTH = 4;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int DIV_STEPS = BPM_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	localparam logic [BPM_W-1:0] MS_PER_MINUTE = 16'd60000;
	localparam logic [BPM_W-1:0] BPM_SATURATED = 16'hFFFF;

	localparam logic [THR_W-1:0]   RST_RISE_THRESHOLD = 15'd300;
	localparam logic [FLOOR_W-1:0] RST_BPM_FLOOR      = 8'd20;
	localparam logic [CEIL_W-1:0]  RST_BPM_CEILING    = 16'd255;

	localparam int PADDR_W = 4;

	typedef enum logic [1:0] {
		REG_RISE_THRESHOLD = 2'd0,
		REG_BPM_FLOOR      = 2'd1,
		REG_BPM_CEILING    = 2'd2
	} pbd_reg_t;

	typedef struct packed {
		logic [THR_W-1:0]   rise_threshold;
		logic [FLOOR_W-1:0] bpm_floor;
		logic [CEIL_W-1:0]  bpm_ceiling;
	} pbd_cfg_t;

	typedef struct packed {
		logic              beat;
		logic [TIME_W-1:0] delta;
	} pbd_job_t;

	typedef struct packed {
		logic              start;
		logic [BPM_W-1:0]  dividend;
		logic [TIME_W-1:0] divisor;
	} pbd_div_req_t;

	typedef struct packed {
		logic wait_div;
		logic div_done;
	} pbd_back_stat_t;

endpackage

`default_nettype wire

// ===== design/pbd_front.sv =====
// ----------------------------------------------------------------------------
// pbd_front
// Accepts samples, tracks slope state and classifies each item as beat or not.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_front import pbd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pbd_cfg_t            cfg,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [SAMPLE_W-1:0] ir_sample,
	input  wire logic [TIME_W-1:0]   time_ms,
	input  wire logic                q_full,
	output logic                     job_push,
	output pbd_job_t                 job
);

	logic [SAMPLE_W-1:0] prev_sample_q;
	logic [SAMPLE_W-1:0] prev_diff_q;
	logic                latched_q;
	logic [TIME_W-1:0]   last_beat_q;

	logic                accept;
	logic [SAMPLE_W-1:0] diff;
	logic [SAMPLE_W-1:0] slope;
	logic                peak_ok;
	logic                beat;
	logic                rearm;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	assign diff    = ir_sample - prev_sample_q;
	assign slope   = diff - prev_diff_q;
	assign peak_ok = $signed(prev_diff_q) > $signed({1'b0, cfg.rise_threshold});
	assign beat    = slope[SAMPLE_W-1] && peak_ok && !latched_q;
	assign rearm   = !slope[SAMPLE_W-1] && (slope != '0);

	assign job_push   = accept;
	assign job.beat   = beat;
	assign job.delta  = time_ms - last_beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sample_q <= '0;
			prev_diff_q   <= '0;
			latched_q     <= 1'b0;
			last_beat_q   <= '0;
		end else if (accept) begin
			prev_sample_q <= ir_sample;
			prev_diff_q   <= diff;
			if (beat) begin
				latched_q   <= 1'b1;
				last_beat_q <= time_ms;
			end else if (rearm) begin
				latched_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/pbd_fifo.sv =====
// ----------------------------------------------------------------------------
// pbd_fifo
// Short job queue between the classifier and the rate engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_fifo import pbd_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire pbd_job_t        push_data,
	input  wire logic            pop,
	output pbd_job_t             pop_data,
	output logic                 full,
	output logic                 empty,
	output logic [QCNT_W-1:0]    count
);

	pbd_job_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign count    = cnt_q;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/pbd_div.sv =====
// ----------------------------------------------------------------------------
// pbd_div
// Restoring divider, one quotient bit per cycle, 16-bit dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_div import pbd_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pbd_div_req_t   req,
	output logic                done,
	output logic [BPM_W-1:0]    quotient,
	output logic [BPM_W-1:0]    remainder
);

	logic [BPM_W-1:0]  quo_q;
	logic [BPM_W-1:0]  rem_q;
	logic [TIME_W-1:0] div_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [BPM_W:0]    trial;
	logic [TIME_W-1:0] trial_ext;
	logic              ge;
	logic [TIME_W-1:0] diff;

	assign trial     = {rem_q, quo_q[BPM_W-1]};
	assign trial_ext = TIME_W'(trial);
	assign ge        = (trial_ext >= div_q);
	assign diff      = trial_ext - div_q;

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[BPM_W-2:0], ge};
			rem_q <= ge ? diff[BPM_W-1:0] : trial[BPM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== design/pbd_back.sv =====
// ----------------------------------------------------------------------------
// pbd_back
// Rate engine: beat rate division, average ring and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_back import pbd_pkg::*; #(
	parameter int RING_DEPTH = PBD_RING_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pbd_cfg_t         cfg,
	input  wire logic             q_empty,
	input  wire pbd_job_t         job,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  out_beat,
	output logic [BPM_W-1:0]      out_bpm_now,
	output logic [AVG_W-1:0]      out_bpm_average,
	output pbd_back_stat_t        stat
);

	localparam int RIDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SUM_W  = AVG_W + $clog2(RING_DEPTH + 1);

	// ring mean as sum * ceil(2^AVG_SHIFT / RING_DEPTH) >> AVG_SHIFT, exact for any sum
	localparam int AVG_SHIFT = SUM_W + RIDX_W;
	localparam int RECIP_W   = AVG_SHIFT + 1;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] AVG_RECIP =
		RECIP_W'(((1 << AVG_SHIFT) + RING_DEPTH - 1) / RING_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RATE,
		ST_AVG,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic               beat_q;
	logic [BPM_W-1:0]   cur_bpm_q;
	logic [AVG_W-1:0]   avg_q;
	logic [AVG_W-1:0]   ring_q [RING_DEPTH];
	logic [RIDX_W-1:0]  pos_q;
	logic [SUM_W-1:0]   sum_q;
	logic               out_valid_q;
	logic               out_beat_q;
	logic [BPM_W-1:0]   out_bpm_q;
	logic [AVG_W-1:0]   out_avg_q;

	pbd_div_req_t       div_req;
	logic               div_done;
	logic [BPM_W-1:0]   div_quo;
	logic [BPM_W-1:0]   div_rem;

	logic               floor_ok;
	logic               ceil_ok;
	logic               in_ring;
	logic [SUM_W-1:0]   sum_next;
	logic               start_rate;
	logic [PROD_W-1:0]  avg_prod;
	logic               emit;

	pbd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// exact limit tests from quotient and remainder
	assign floor_ok = (BPM_W'(cfg.bpm_floor) < div_quo) ||
		((BPM_W'(cfg.bpm_floor) == div_quo) && (div_rem != '0));
	assign ceil_ok  = (cfg.bpm_ceiling > div_quo);
	assign in_ring  = floor_ok && ceil_ok;
	assign sum_next = sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(div_quo[AVG_W-1:0]);
	assign avg_prod = PROD_W'(sum_q) * PROD_W'(AVG_RECIP);

	assign q_pop      = (state_q == ST_IDLE) && !q_empty;
	assign start_rate = q_pop && job.beat && (job.delta != '0);
	assign emit       = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	assign div_req.start    = start_rate;
	assign div_req.dividend = MS_PER_MINUTE;
	assign div_req.divisor  = job.delta;

	assign stat.wait_div = (state_q == ST_RATE);
	assign stat.div_done = div_done;

	assign out_valid       = out_valid_q;
	assign out_beat        = out_beat_q;
	assign out_bpm_now     = out_bpm_q;
	assign out_bpm_average = out_avg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			beat_q      <= 1'b0;
			cur_bpm_q   <= '0;
			avg_q       <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			out_beat_q  <= 1'b0;
			out_bpm_q   <= '0;
			out_avg_q   <= '0;
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						beat_q <= job.beat;
						if (start_rate) begin
							state_q <= ST_RATE;
						end else begin
							if (job.beat) begin
								cur_bpm_q <= BPM_SATURATED;
							end
							state_q <= ST_EMIT;
						end
					end
				end
				ST_RATE: begin
					if (div_done) begin
						cur_bpm_q <= div_quo;
						if (in_ring) begin
							ring_q[pos_q] <= div_quo[AVG_W-1:0];
							pos_q <= (pos_q == RIDX_W'(RING_DEPTH - 1)) ? '0 : pos_q + 1'b1;
							sum_q <= sum_next;
							state_q <= ST_AVG;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_AVG: begin
					avg_q   <= avg_prod[AVG_SHIFT +: AVG_W];
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						out_beat_q  <= beat_q;
						out_bpm_q   <= cur_bpm_q;
						out_avg_q   <= avg_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/pulse_beat_detect_bpm_average.sv =====
// ----------------------------------------------------------------------------
// pulse_beat_detect_bpm_average
// Slope-reversal heartbeat detector with beat rate and rate average.
// ----------------------------------------------------------------------------
// Input stream: one item per sample, tdata = {time_ms, ir_sample}. Output
// stream: exactly one item per input item, tuser = beat, tdata =
// {bpm_average, bpm_now}. APB registers: rise_threshold at 0x0, bpm_floor at
// 0x4, bpm_ceiling at 0x8; write them only while the block is idle.
// The classifier queues each accepted item (two entries). The rate engine
// passes an item without a beat (or with zero elapsed time) from idle
// straight to emit; a beat waits on the serial divider, then goes to emit if
// its rate stays out of the ring, or takes the ring mean first if it enters it.
// Reset clears the ring and all control and result state and loads the
// register defaults. On a receiver stall the result is held, the engine
// finishes the next item and waits, then the queue fills and s_axis_tready
// drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pulse_beat_detect_bpm_average import pbd_pkg::*; #(
	parameter int RING_DEPTH = PBD_RING_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [47:0]         s_axis_tdata,  // ir_sample[15:0], time_ms[47:16]
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [23:0]              m_axis_tdata,  // bpm_now[15:0], bpm_average[23:16]
	output logic                     m_axis_tuser,  // beat
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	logic [THR_W-1:0]   rise_threshold_q;
	logic [FLOOR_W-1:0] bpm_floor_q;
	logic [CEIL_W-1:0]  bpm_ceiling_q;
	pbd_cfg_t           cfg;
	pbd_reg_t           reg_sel;
	logic               cfg_wr;

	logic               job_push;
	pbd_job_t           job_in;
	pbd_job_t           job_out;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;
	logic [QCNT_W-1:0]  q_count;
	pbd_back_stat_t     back_stat;

	logic [BPM_W-1:0]   bpm_now;
	logic [AVG_W-1:0]   bpm_average;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = pbd_reg_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_threshold_q <= RST_RISE_THRESHOLD;
			bpm_floor_q      <= RST_BPM_FLOOR;
			bpm_ceiling_q    <= RST_BPM_CEILING;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_RISE_THRESHOLD: rise_threshold_q <= pwdata[THR_W-1:0];
				REG_BPM_FLOOR:      bpm_floor_q      <= pwdata[FLOOR_W-1:0];
				REG_BPM_CEILING:    bpm_ceiling_q    <= pwdata[CEIL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_RISE_THRESHOLD: prdata = 32'(rise_threshold_q);
			REG_BPM_FLOOR:      prdata = 32'(bpm_floor_q);
			REG_BPM_CEILING:    prdata = 32'(bpm_ceiling_q);
			default:            prdata = '0;
		endcase
	end

	assign cfg.rise_threshold = rise_threshold_q;
	assign cfg.bpm_floor      = bpm_floor_q;
	assign cfg.bpm_ceiling    = bpm_ceiling_q;

	pbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.ir_sample (s_axis_tdata[15:0]),
		.time_ms   (s_axis_tdata[47:16]),
		.q_full    (q_full),
		.job_push  (job_push),
		.job       (job_in)
	);

	pbd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.pop       (q_pop),
		.pop_data  (job_out),
		.full      (q_full),
		.empty     (q_empty),
		.count     (q_count)
	);

	pbd_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.q_empty         (q_empty),
		.job             (job_out),
		.q_pop           (q_pop),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_beat        (m_axis_tuser),
		.out_bpm_now     (bpm_now),
		.out_bpm_average (bpm_average),
		.stat            (back_stat)
	);

	assign m_axis_tdata = {bpm_average, bpm_now};

	`ASSERT_NEXT(a_push_lands, clk, arst_n, s_axis_tvalid && s_axis_tready, q_count != '0)
	`ASSERT_IMPLIES(a_queue_bound, clk, arst_n, 1'b1, q_count <= QCNT_W'(QUEUE_DEPTH))
	`ASSERT_IMPLIES(a_div_owned, clk, arst_n, back_stat.div_done, back_stat.wait_div)

endmodule

`default_nettype wire

// ===== dv/pulse_beat_detect_bpm_average_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_beat_detect_bpm_average_checker
// Watches the sample, result and register channels of the beat detector. It
// keeps its own copy of the detector state and registers, predicts one result
// per accepted sample item and compares every accepted result with the oldest
// prediction. Hands the mismatch count and the number of outstanding results
// to the testbench top.
// ----------------------------------------------------------------------------
module pulse_beat_detect_bpm_average_checker import pbd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	input  logic               s_axis_tready,
	input  logic [47:0]        s_axis_tdata,  // ir_sample[15:0], time_ms[47:16]
	input  logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  logic [23:0]        m_axis_tdata,  // bpm_now[15:0], bpm_average[23:16]
	input  logic               m_axis_tuser,  // beat
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 pending
);

	localparam int MAX_REPORTS = 100;
	localparam logic [31:0] MINUTE_MS = 32'd60000;

	typedef struct packed {
		logic             beat;
		logic [BPM_W-1:0] bpm_now;
		logic [AVG_W-1:0] bpm_avg;
	} beat_result_t;

	logic [THR_W-1:0]    thr;
	logic [FLOOR_W-1:0]  floor_bpm;
	logic [CEIL_W-1:0]   ceil_bpm;

	logic [SAMPLE_W-1:0] last_sample;
	logic [SAMPLE_W-1:0] last_diff;
	logic                latched;
	logic [TIME_W-1:0]   last_beat_ms;
	logic [AVG_W-1:0]    rates [PBD_RING_DEPTH];
	int                  wr_pos;
	logic [BPM_W-1:0]    rate_now;
	logic [AVG_W-1:0]    rate_avg;

	beat_result_t        expected_beats [$];
	int                  fail_cnt;

	function automatic beat_result_t predict_beat(input logic [SAMPLE_W-1:0] smp,
			input logic [TIME_W-1:0] now);
		logic [SAMPLE_W-1:0] diff;
		logic [SAMPLE_W-1:0] slope;
		logic [TIME_W-1:0]   delta;
		logic [31:0]         rate;
		logic [63:0]         d64;
		int unsigned         sum;
		int                  pd;
		int                  sl;
		beat_result_t        r;
		diff  = smp - last_sample;
		slope = diff - last_diff;
		pd    = int'($signed(last_diff));
		sl    = int'($signed(slope));
		r.beat = 1'b0;
		if (sl < 0 && pd > int'(thr) && !latched) begin
			delta        = now - last_beat_ms;
			last_beat_ms = now;
			rate         = (delta == 0) ? 32'(BPM_SATURATED) : MINUTE_MS / delta;
			rate_now     = rate[BPM_W-1:0];
			d64          = {32'd0, delta};
			if (64'(MINUTE_MS) < 64'(ceil_bpm) * d64 && 64'(MINUTE_MS) > 64'(floor_bpm) * d64) begin
				rates[wr_pos] = rate[AVG_W-1:0];
				wr_pos = (wr_pos + 1) % PBD_RING_DEPTH;
				sum = 0;
				for (int i = 0; i < PBD_RING_DEPTH; i++) begin
					sum += rates[i];
				end
				rate_avg = AVG_W'(sum / PBD_RING_DEPTH);
			end
			r.beat  = 1'b1;
			latched = 1'b1;
		end
		if (sl > 0) begin
			latched = 1'b0;
		end
		last_diff   = diff;
		last_sample = smp;
		r.bpm_now   = rate_now;
		r.bpm_avg   = rate_avg;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		beat_result_t want;
		beat_result_t got;
		if (!arst_n) begin
			thr          = RST_RISE_THRESHOLD;
			floor_bpm    = RST_BPM_FLOOR;
			ceil_bpm     = RST_BPM_CEILING;
			last_sample  = '0;
			last_diff    = '0;
			latched      = 1'b0;
			last_beat_ms = '0;
			for (int i = 0; i < PBD_RING_DEPTH; i++) begin
				rates[i] = '0;
			end
			wr_pos   = 0;
			rate_now = '0;
			rate_avg = '0;
			expected_beats.delete();
			fail_cnt = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (pbd_reg_t'(paddr[PADDR_W-1:2]))
					REG_RISE_THRESHOLD: thr = pwdata[THR_W-1:0];
					REG_BPM_FLOOR:      floor_bpm = pwdata[FLOOR_W-1:0];
					REG_BPM_CEILING:    ceil_bpm = pwdata[CEIL_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_beats.push_back(predict_beat(s_axis_tdata[15:0], s_axis_tdata[47:16]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.beat    = m_axis_tuser;
				got.bpm_now = m_axis_tdata[15:0];
				got.bpm_avg = m_axis_tdata[23:16];
				if (expected_beats.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("%0t ns: unexpected result item: beat=%0d bpm_now=%0d bpm_average=%0d",
							$time, got.beat, got.bpm_now, got.bpm_avg);
				end else begin
					want = expected_beats.pop_front();
					if (got.beat !== want.beat || got.bpm_now !== want.bpm_now ||
							got.bpm_avg !== want.bpm_avg) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORTS)
							$display("%0t ns: mismatch: expected beat=%0d bpm_now=%0d bpm_average=%0d, got beat=%0d bpm_now=%0d bpm_average=%0d",
								$time, want.beat, want.bpm_now, want.bpm_avg,
								got.beat, got.bpm_now, got.bpm_avg);
					end
				end
			end
			mismatches <= fail_cnt;
			pending    <= expected_beats.size();
		end
	end

endmodule

// ===== dv/pulse_beat_detect_bpm_average_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_beat_detect_bpm_average_tb
// Drives sample items into the beat detector: a short directed sequence, then
// random pulse shaped runs mixed with noise under several register settings
// and idle patterns on both stream sides. The checker predicts and compares;
// this module gives the verdict.
// ----------------------------------------------------------------------------
module pulse_beat_detect_bpm_average_tb;
	import pbd_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_LEN   = 60;
	localparam int ITEMS_PHASE  = 105;
	localparam int PHASES       = 6;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [47:0]        s_axis_tdata;   // ir_sample[15:0], time_ms[47:16]
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [23:0]        m_axis_tdata;   // bpm_now[15:0], bpm_average[23:16]
	logic               m_axis_tuser;   // beat
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int                 mismatches;
	int                 pending;
	int                 send_idle_pct;
	int                 ready_stall_pct;
	int                 items_sent;
	int                 cycles;
	int                 thr_now;
	logic [15:0]        cur_sample;
	logic [31:0]        cur_time;

	pulse_beat_detect_bpm_average dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	pulse_beat_detect_bpm_average_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
	end

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_config(input int t, input int f, input int c);
		apb_write(PADDR_W'({REG_RISE_THRESHOLD, 2'b00}), {17'($urandom()), 15'(t)});
		apb_write(PADDR_W'({REG_BPM_FLOOR, 2'b00}), {24'($urandom()), 8'(f)});
		apb_write(PADDR_W'({REG_BPM_CEILING, 2'b00}), {16'($urandom()), 16'(c)});
		thr_now = t;
	endtask

	task automatic send_item(input logic [15:0] smp, input logic [31:0] t);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {t, smp};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_LEN) @(posedge clk);
	endtask

	// rise with a steady slope, a smaller step at the top, then a fall
	task automatic pulse_run();
		int          nrise;
		int          nfall;
		int          m;
		logic [15:0] step;
		logic [31:0] dt;
		nrise = $urandom_range(1, 5);
		nfall = $urandom_range(1, 6);
		step  = 16'(thr_now) + 16'($urandom_range(1, 2500));
		if ($urandom_range(9) == 0)
			step = 16'($urandom_range(0, thr_now));
		m = $urandom_range(99);
		if (m < 5)
			dt = 0;
		else if (m < 80)
			dt = $urandom_range(20, 120);
		else if (m < 95)
			dt = $urandom_range(1, 15);
		else
			dt = $urandom_range(1000, 70000);
		for (int i = 0; i < nrise; i++) begin
			cur_sample += step;
			cur_time   += dt;
			send_item(cur_sample, cur_time);
		end
		cur_sample += 16'($urandom_range(0, step >> 1));
		cur_time   += dt;
		send_item(cur_sample, cur_time);
		for (int i = 0; i < nfall; i++) begin
			cur_sample -= 16'($urandom_range(0, 3000));
			cur_time   += dt;
			send_item(cur_sample, cur_time);
		end
	endtask

	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			cur_sample = 16'($urandom());
			if ($urandom_range(3) == 0)
				cur_time = $urandom();
			else
				cur_time += $urandom_range(0, 200);
			send_item(cur_sample, cur_time);
		end
	endtask

	initial begin
		int target;
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		m_axis_tready   = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		send_idle_pct   = 0;
		ready_stall_pct = 0;
		items_sent      = 0;
		cycles          = 0;
		thr_now         = int'(RST_RISE_THRESHOLD);
		cur_sample      = '0;
		cur_time        = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero elapsed time, held peak, rearm, wrap of sample and time
		send_item(16'd0,     32'd0);
		send_item(16'd1000,  32'd0);
		send_item(16'd1500,  32'd0);
		send_item(16'hFFFF,  32'd10);
		send_item(16'd0,     32'd20);
		send_item(16'h7FFF,  32'd30);
		send_item(16'h8000,  32'd40);
		send_item(16'h8000,  32'd540);
		send_item(16'd33768, 32'd1040);
		send_item(16'd34000, 32'd1540);
		send_item(16'd30000, 32'd1600);
		send_item(16'd31000, 32'd1700);
		send_item(16'd31100, 32'd2040);
		send_item(16'd20000, 32'd2100);
		send_item(16'd21000, 32'd2200);
		send_item(16'd21000, 32'hFFFF_FFF0);
		send_item(16'd0,     32'hFFFF_FFFF);
		send_item(16'd1000,  32'hFFFF_FFFF);
		send_item(16'd1001,  32'h0000_0010);
		send_item(16'hFFFF,  32'hAAAA_5555);
		send_item(16'hFFFF,  32'h5555_AAAA);
		cur_sample = 16'hFFFF;
		cur_time   = 32'h5555_AAAA;

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				wait_idle();
				case (ph)
					1: write_config(0, 0, 65535);
					2: write_config(32767, 255, 0);
					3: write_config(150, 40, 180);
					4: write_config(1000, 255, 300);
					default: begin
						write_config(300, 20, 255);
						apb_write(PADDR_W'(12), $urandom());
					end
				endcase
				if (ph == 3)
					cur_time = 32'hFFFF_F000;
			end
			case (ph % 4)
				0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
				1: begin send_idle_pct = 76; ready_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  ready_stall_pct = 76; end
				default: begin send_idle_pct = 13; ready_stall_pct = 13; end
			endcase
			target = items_sent + ITEMS_PHASE;
			while (items_sent < target) begin
				if ($urandom_range(49) == 0)
					wait_idle();
				if ($urandom_range(99) < 80)
					pulse_run();
				else
					noise_burst();
			end
		end

		wait_idle();
		if (mismatches == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
